[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the lowest common ancestor unit.
// Depends on nothing; files that use BLL_ASSERT must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define BLL_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion on the module's own clk_i and rst_ni.
`define BLL_ASSERT(lbl, prop, msg) `BLL_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/bllca_pkg.sv]
// Shared types and constants of the binary lifting lowest common ancestor unit.
// Depends on nothing; used by the controller, the memories and the top level.
package bllca_pkg;

  // Width of every node number and depth on the ports.
  localparam int NodeW = 10;

  // Default tree size and number of lifting levels.
  localparam int DefNodes  = 1024;
  localparam int DefLevels = 10;

  typedef logic [NodeW-1:0] node_t;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLD_RD1,
    ST_BLD_RD2,
    ST_BLD_WR,
    ST_Q_DEP,
    ST_Q_LIFT,
    ST_Q_DESC,
    ST_Q_LAST,
    ST_Q_FIN,
    ST_Q_RES
  } state_e;

  // Controller status seen by the top level.
  typedef struct packed {
    state_e state;
    node_t  node_a;
    node_t  node_b;
  } ctrl_status_t;

endpackage

[hw/rtl/binary_lifting_lca_unit.sv]
// Top level of the binary lifting lowest common ancestor unit.
// Instantiates bllca_ctrl, bllca_jump_mem and bllca_depth_mem; uses bllca_pkg.
//
// The unit answers lowest common ancestor queries over a rooted tree of up to
// NODES nodes. The tree is given one node per load word (parent and depth, the
// root named as its own parent); a build word then fills the jump table, and
// query words name two nodes and return one word with their common ancestor.
// A load is written in the cycle it is accepted. A build walks the table one
// entry at a time, level by level, since each entry needs two dependent reads
// of the jump memory. A query runs from acceptance until the unit is free again
// through one depth read, one lifting step per bit of the depth difference of
// the two nodes, one descent step per level with both nodes read in parallel on
// the two read ports of the jump memory, then the parent read and the output
// transfer. When the lifted node already equals the other node, the descent is
// skipped; a query naming a node outside the tree goes straight to the output
// transfer. A stalled output register holds a finished query until the receiver
// takes the previous result. The unit works on one word at a time and takes the
// next word while a finished result still sits in the output register. The
// memories come up undefined and have no clearing pass; nodes must be loaded and
// the table built before a query touches them. A query that follows a load reads
// the just-written entry correctly, since loads write in the cycle of acceptance.
`include "assert_macros.svh"

module binary_lifting_lca_unit #(
  parameter int NODES  = bllca_pkg::DefNodes,
  parameter int LEVELS = bllca_pkg::DefLevels
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  bllca_pkg::node_t node_a_i,
  input  bllca_pkg::node_t node_b_i,
  input  bllca_pkg::node_t parent_node_i,
  input  bllca_pkg::node_t depth_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bllca_pkg::node_t ancestor_node_o
);

  localparam int AW = $clog2(NODES);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // Jump memory port signals.
  logic             jmp_we;
  logic [AW-1:0]    jmp_wnode;
  logic [LW-1:0]    jmp_wlvl;
  bllca_pkg::node_t jmp_wdata;
  logic [AW-1:0]    jmp_ra_node;
  logic [LW-1:0]    jmp_ra_lvl;
  logic [AW-1:0]    jmp_rb_node;
  logic [LW-1:0]    jmp_rb_lvl;
  bllca_pkg::node_t jmp_rdata_a;
  bllca_pkg::node_t jmp_rdata_b;

  // Depth memory port signals.
  logic             dep_we;
  logic [AW-1:0]    dep_waddr;
  bllca_pkg::node_t dep_wdata;
  logic [AW-1:0]    dep_raddr_a;
  logic [AW-1:0]    dep_raddr_b;
  bllca_pkg::node_t dep_rdata_a;
  bllca_pkg::node_t dep_rdata_b;

  bllca_pkg::ctrl_status_t status;

  bllca_ctrl #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .node_a_i        (node_a_i),
    .node_b_i        (node_b_i),
    .parent_node_i   (parent_node_i),
    .depth_value_i   (depth_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ancestor_node_o (ancestor_node_o),
    .jmp_we_o        (jmp_we),
    .jmp_wnode_o     (jmp_wnode),
    .jmp_wlvl_o      (jmp_wlvl),
    .jmp_wdata_o     (jmp_wdata),
    .jmp_ra_node_o   (jmp_ra_node),
    .jmp_ra_lvl_o    (jmp_ra_lvl),
    .jmp_rb_node_o   (jmp_rb_node),
    .jmp_rb_lvl_o    (jmp_rb_lvl),
    .jmp_rdata_a_i   (jmp_rdata_a),
    .jmp_rdata_b_i   (jmp_rdata_b),
    .dep_we_o        (dep_we),
    .dep_waddr_o     (dep_waddr),
    .dep_wdata_o     (dep_wdata),
    .dep_raddr_a_o   (dep_raddr_a),
    .dep_raddr_b_o   (dep_raddr_b),
    .dep_rdata_a_i   (dep_rdata_a),
    .dep_rdata_b_i   (dep_rdata_b),
    .status_o        (status)
  );

  bllca_jump_mem #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_jump_mem (
    .clk_i     (clk_i),
    .we_i      (jmp_we),
    .wnode_i   (jmp_wnode),
    .wlvl_i    (jmp_wlvl),
    .wdata_i   (jmp_wdata),
    .ra_node_i (jmp_ra_node),
    .ra_lvl_i  (jmp_ra_lvl),
    .rb_node_i (jmp_rb_node),
    .rb_lvl_i  (jmp_rb_lvl),
    .rdata_a_o (jmp_rdata_a),
    .rdata_b_o (jmp_rdata_b)
  );

  bllca_depth_mem #(
    .NODES (NODES)
  ) u_depth_mem (
    .clk_i     (clk_i),
    .we_i      (dep_we),
    .waddr_i   (dep_waddr),
    .wdata_i   (dep_wdata),
    .raddr_a_i (dep_raddr_a),
    .raddr_b_i (dep_raddr_b),
    .rdata_a_o (dep_rdata_a),
    .rdata_b_o (dep_rdata_b)
  );

  // A load finishes in the cycle it is accepted, so the unit is free again.
  `BLL_ASSERT(a_load_one_cycle, in_valid_i && !in_stall_o && (op_i == bllca_pkg::OP_LOAD) |=> !in_stall_o, "load word did not leave the unit free")

  // A result word only appears after the controller held a finished query.
  `BLL_ASSERT(a_result_from_query, $rose(out_valid_o) |-> $past(status.state == bllca_pkg::ST_Q_RES), "result word without a finished query")

  // During the descent the two nodes stay apart; they only jump to differing ancestors.
  `BLL_ASSERT(a_descent_apart, (status.state == bllca_pkg::ST_Q_DESC) |-> (status.node_a != status.node_b), "descent nodes became equal")

endmodule

[hw/rtl/bllca_depth_mem.sv]
// Depth memory: one entry per node, one write port and two registered read ports.
// Depends on bllca_pkg for the node type.
module bllca_depth_mem #(
  parameter int NODES = bllca_pkg::DefNodes
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(NODES)-1:0]       waddr_i,
  input  bllca_pkg::node_t               wdata_i,
  input  logic [$clog2(NODES)-1:0]       raddr_a_i,
  input  logic [$clog2(NODES)-1:0]       raddr_b_i,
  output bllca_pkg::node_t               rdata_a_o,
  output bllca_pkg::node_t               rdata_b_o
);

  bllca_pkg::node_t mem_q [NODES];
  bllca_pkg::node_t rdata_a_q;
  bllca_pkg::node_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[hw/rtl/bllca_jump_mem.sv]
// Jump table memory: entry (node, level) holds the 2^level-th ancestor of node.
// One write port and two registered read ports. Depends on bllca_pkg.
module bllca_jump_mem #(
  parameter int NODES  = bllca_pkg::DefNodes,
  parameter int LEVELS = bllca_pkg::DefLevels
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [$clog2(NODES)-1:0]                     wnode_i,
  input  logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] wlvl_i,
  input  bllca_pkg::node_t                             wdata_i,
  input  logic [$clog2(NODES)-1:0]                     ra_node_i,
  input  logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] ra_lvl_i,
  input  logic [$clog2(NODES)-1:0]                     rb_node_i,
  input  logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] rb_lvl_i,
  output bllca_pkg::node_t                             rdata_a_o,
  output bllca_pkg::node_t                             rdata_b_o
);

  localparam int AW    = $clog2(NODES);
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int Depth = NODES << LW;

  bllca_pkg::node_t mem_q [Depth];
  bllca_pkg::node_t rdata_a_q;
  bllca_pkg::node_t rdata_b_q;

  logic [AW+LW-1:0] waddr;
  logic [AW+LW-1:0] raddr_a;
  logic [AW+LW-1:0] raddr_b;

  assign waddr   = {wnode_i, wlvl_i};
  assign raddr_a = {ra_node_i, ra_lvl_i};
  assign raddr_b = {rb_node_i, rb_lvl_i};

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a];
    rdata_b_q <= mem_q[raddr_b];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[hw/rtl/bllca_ctrl.sv]
// Sequencer of the lowest common ancestor unit: loads, table build and queries.
// Drives both memories and holds the output register. Depends on bllca_pkg.
module bllca_ctrl #(
  parameter int NODES  = bllca_pkg::DefNodes,
  parameter int LEVELS = bllca_pkg::DefLevels
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  logic [1:0]                                   op_i,
  input  bllca_pkg::node_t                             node_a_i,
  input  bllca_pkg::node_t                             node_b_i,
  input  bllca_pkg::node_t                             parent_node_i,
  input  bllca_pkg::node_t                             depth_value_i,
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output bllca_pkg::node_t                             ancestor_node_o,
  output logic                                         jmp_we_o,
  output logic [$clog2(NODES)-1:0]                     jmp_wnode_o,
  output logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] jmp_wlvl_o,
  output bllca_pkg::node_t                             jmp_wdata_o,
  output logic [$clog2(NODES)-1:0]                     jmp_ra_node_o,
  output logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] jmp_ra_lvl_o,
  output logic [$clog2(NODES)-1:0]                     jmp_rb_node_o,
  output logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] jmp_rb_lvl_o,
  input  bllca_pkg::node_t                             jmp_rdata_a_i,
  input  bllca_pkg::node_t                             jmp_rdata_b_i,
  output logic                                         dep_we_o,
  output logic [$clog2(NODES)-1:0]                     dep_waddr_o,
  output bllca_pkg::node_t                             dep_wdata_o,
  output logic [$clog2(NODES)-1:0]                     dep_raddr_a_o,
  output logic [$clog2(NODES)-1:0]                     dep_raddr_b_o,
  input  bllca_pkg::node_t                             dep_rdata_a_i,
  input  bllca_pkg::node_t                             dep_rdata_b_i,
  output bllca_pkg::ctrl_status_t                      status_o
);

  localparam int AW    = $clog2(NODES);
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LiftN = (LEVELS < bllca_pkg::NodeW) ? LEVELS : bllca_pkg::NodeW;
  localparam bllca_pkg::node_t LiftMask = bllca_pkg::node_t'((32'd1 << LiftN) - 32'd1);

  bllca_pkg::state_e state_q, state_d;
  bllca_pkg::node_t  a_q, a_d;
  bllca_pkg::node_t  b_q, b_d;
  bllca_pkg::node_t  diff_q, diff_d;
  bllca_pkg::node_t  res_q, res_d;
  bllca_pkg::node_t  out_data_q, out_data_d;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic [AW-1:0]     bn_q, bn_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;

  bllca_pkg::node_t  a_lift;
  bllca_pkg::node_t  a_desc;
  bllca_pkg::node_t  b_desc;
  logic              desc_jump;
  logic              slot_free;
  logic              a_in_range;
  logic              b_in_range;
  logic              par_in_range;
  logic [AW-1:0]     bld_mid;

  // The pending flag says that a read was issued last cycle, so the jump memory data
  // replaces the held node; in the descent, only where the two read nodes differ.
  assign a_lift    = pend_q ? jmp_rdata_a_i : a_q;
  assign desc_jump = pend_q && (jmp_rdata_a_i != jmp_rdata_b_i);
  assign a_desc    = desc_jump ? jmp_rdata_a_i : a_q;
  assign b_desc    = desc_jump ? jmp_rdata_b_i : b_q;

  assign slot_free    = !out_valid_q || !out_stall_i;
  assign a_in_range   = int'(node_a_i) < NODES;
  assign b_in_range   = int'(node_b_i) < NODES;
  assign par_in_range = int'(parent_node_i) < NODES;
  assign bld_mid      = (int'(jmp_rdata_a_i) < NODES) ? AW'(jmp_rdata_a_i) : bn_q;

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    diff_d      = diff_q;
    res_d       = res_q;
    lvl_d       = lvl_q;
    bn_d        = bn_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    in_stall_o    = 1'b1;
    jmp_we_o      = 1'b0;
    jmp_wnode_o   = bn_q;
    jmp_wlvl_o    = lvl_q;
    jmp_wdata_o   = jmp_rdata_a_i;
    jmp_ra_node_o = '0;
    jmp_ra_lvl_o  = '0;
    jmp_rb_node_o = '0;
    jmp_rb_lvl_o  = '0;
    dep_we_o      = 1'b0;
    dep_waddr_o   = AW'(node_a_i);
    dep_wdata_o   = depth_value_i;
    dep_raddr_a_o = AW'(node_a_i);
    dep_raddr_b_o = AW'(node_b_i);

    unique case (state_q)
      bllca_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (op_i)
            bllca_pkg::OP_LOAD: begin
              if (a_in_range) begin
                jmp_we_o    = 1'b1;
                jmp_wnode_o = AW'(node_a_i);
                jmp_wlvl_o  = '0;
                jmp_wdata_o = par_in_range ? parent_node_i : node_a_i;
                dep_we_o    = 1'b1;
              end
            end
            bllca_pkg::OP_BUILD: begin
              if (LEVELS > 1) begin
                bn_d    = '0;
                lvl_d   = LW'(1);
                state_d = bllca_pkg::ST_BLD_RD1;
              end
            end
            bllca_pkg::OP_QUERY: begin
              a_d = node_a_i;
              b_d = node_b_i;
              if (a_in_range && b_in_range) begin
                state_d = bllca_pkg::ST_Q_DEP;
              end else begin
                res_d   = '0;
                state_d = bllca_pkg::ST_Q_RES;
              end
            end
            default: begin
            end
          endcase
        end
      end

      bllca_pkg::ST_BLD_RD1: begin
        jmp_ra_node_o = bn_q;
        jmp_ra_lvl_o  = lvl_q - LW'(1);
        state_d       = bllca_pkg::ST_BLD_RD2;
      end

      bllca_pkg::ST_BLD_RD2: begin
        jmp_ra_node_o = bld_mid;
        jmp_ra_lvl_o  = lvl_q - LW'(1);
        state_d       = bllca_pkg::ST_BLD_WR;
      end

      bllca_pkg::ST_BLD_WR: begin
        // Write this entry and start the first read of the next one.
        jmp_we_o = 1'b1;
        if (bn_q == AW'(NODES - 1)) begin
          bn_d = '0;
          if (lvl_q == LW'(LEVELS - 1)) begin
            state_d = bllca_pkg::ST_IDLE;
          end else begin
            lvl_d         = lvl_q + LW'(1);
            jmp_ra_node_o = '0;
            jmp_ra_lvl_o  = lvl_q;
            state_d       = bllca_pkg::ST_BLD_RD2;
          end
        end else begin
          bn_d          = bn_q + AW'(1);
          jmp_ra_node_o = bn_q + AW'(1);
          jmp_ra_lvl_o  = lvl_q - LW'(1);
          state_d       = bllca_pkg::ST_BLD_RD2;
        end
      end

      bllca_pkg::ST_Q_DEP: begin
        if (dep_rdata_a_i < dep_rdata_b_i) begin
          a_d    = b_q;
          b_d    = a_q;
          diff_d = (dep_rdata_b_i - dep_rdata_a_i) & LiftMask;
        end else begin
          diff_d = (dep_rdata_a_i - dep_rdata_b_i) & LiftMask;
        end
        lvl_d   = '0;
        state_d = bllca_pkg::ST_Q_LIFT;
      end

      bllca_pkg::ST_Q_LIFT: begin
        a_d = a_lift;
        if (diff_q != '0) begin
          jmp_ra_node_o = AW'(a_lift);
          jmp_ra_lvl_o  = lvl_q;
          pend_d        = diff_q[0];
          diff_d        = diff_q >> 1;
          lvl_d         = lvl_q + LW'(1);
        end else if (a_lift == b_q) begin
          res_d   = a_lift;
          state_d = bllca_pkg::ST_Q_RES;
        end else begin
          lvl_d   = LW'(LEVELS - 1);
          state_d = bllca_pkg::ST_Q_DESC;
        end
      end

      bllca_pkg::ST_Q_DESC: begin
        a_d           = a_desc;
        b_d           = b_desc;
        jmp_ra_node_o = AW'(a_desc);
        jmp_ra_lvl_o  = lvl_q;
        jmp_rb_node_o = AW'(b_desc);
        jmp_rb_lvl_o  = lvl_q;
        pend_d        = 1'b1;
        if (lvl_q == '0) begin
          state_d = bllca_pkg::ST_Q_LAST;
        end else begin
          lvl_d = lvl_q - LW'(1);
        end
      end

      bllca_pkg::ST_Q_LAST: begin
        a_d           = a_desc;
        b_d           = b_desc;
        jmp_ra_node_o = AW'(a_desc);
        jmp_ra_lvl_o  = '0;
        state_d       = bllca_pkg::ST_Q_FIN;
      end

      bllca_pkg::ST_Q_FIN: begin
        res_d   = jmp_rdata_a_i;
        state_d = bllca_pkg::ST_Q_RES;
      end

      bllca_pkg::ST_Q_RES: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = bllca_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bllca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bllca_pkg::ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    diff_q     <= diff_d;
    res_q      <= res_d;
    lvl_q      <= lvl_d;
    bn_q       <= bn_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o     = out_valid_q;
  assign ancestor_node_o = out_data_q;

  assign status_o.state  = state_q;
  assign status_o.node_a = a_q;
  assign status_o.node_b = b_q;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for binary_lifting_lca_unit: loads random rooted trees, builds the
// jump table and checks every query answer against an in-bench lowest common ancestor predictor.
// Depends on bllca_pkg and the binary_lifting_lca_unit RTL.
`timescale 1ns / 100ps

module tb_top;

  typedef bllca_pkg::node_t node_t;

  localparam int NODES  = bllca_pkg::DefNodes;
  localparam int LEVELS = bllca_pkg::DefLevels;

  // Op value 3 has no meaning in the unit and must be dropped without an answer.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Drain time after the last answer; it outlasts a whole query, so this covers any late word.
  localparam int DrainCycles = 4 * LEVELS + 16;

  // Six builds dominate the run; this is several times the slowest case.
  localparam int LimitNs = 10_000_000;

  // Receiver hold-offs long enough to back the unit up into its input.
  localparam int HoldCycles = 300;

  // One input word as the sender will present it.
  typedef struct {
    logic [1:0] op;
    node_t      a;
    node_t      b;
    node_t      par;
    node_t      dep;
  } tree_word_t;

  logic  clk_i         = 1'b0;
  logic  rst_ni        = 1'b0;
  logic  in_valid_i    = 1'b0;
  logic  in_stall_o;
  logic  [1:0] op_i    = '0;
  node_t node_a_i      = '0;
  node_t node_b_i      = '0;
  node_t parent_node_i = '0;
  node_t depth_value_i = '0;
  logic  out_valid_o;
  logic  out_stall_i   = 1'b0;
  node_t ancestor_node_o;

  binary_lifting_lca_unit #(
    .NODES (NODES),
    .LEVELS(LEVELS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .parent_node_i  (parent_node_i),
    .depth_value_i  (depth_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ancestor_node_o(ancestor_node_o)
  );

  // Words waiting to be offered, and the ancestors still owed by the unit, oldest first.
  tree_word_t pending_q [$];
  node_t      lca_due_q [$];

  // The predictor's own copy of the unit's tables. Entry (n, k) of the ancestor table is
  // the 2^k-th ancestor of node n.
  node_t ancestor_tab [NODES][LEVELS];
  node_t depth_tab [NODES];

  bit in_taken;
  int words_sent;
  int answers_seen;
  int fails;
  int hold_left;
  int hold_marks;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(LimitNs);
    $display("binary_lifting_lca_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // A load records the parent at level 0 and the depth. A parent outside the tree makes the
  // node a root of its own.
  function automatic void lca_store(node_t n, node_t p, node_t d);
    if (n >= NODES) return;
    if (p >= NODES) p = n;
    ancestor_tab[n][0] = p;
    depth_tab[n] = d;
  endfunction

  // Level k is level k-1 applied twice. Every node is walked, loaded or not, just as the
  // unit does it.
  function automatic void lca_rebuild();
    node_t mid;
    for (int k = 1; k < LEVELS; k++) begin
      for (int n = 0; n < NODES; n++) begin
        mid = ancestor_tab[n][k-1];
        if (mid >= NODES) mid = node_t'(n);
        ancestor_tab[n][k] = ancestor_tab[mid][k-1];
      end
    end
  endfunction

  // Lift the deeper node by the depth difference, then descend both from the top level
  // while their ancestors differ; the answer is the parent where they meet.
  function automatic node_t lca_answer(node_t a, node_t b);
    node_t       x;
    node_t       y;
    node_t       t;
    int unsigned gap;
    if (a >= NODES || b >= NODES) return '0;
    x = a;
    y = b;
    if (depth_tab[x] < depth_tab[y]) begin
      t = x;
      x = y;
      y = t;
    end
    gap = int'(depth_tab[x]) - int'(depth_tab[y]);
    for (int k = 0; k < LEVELS; k++) begin
      if (((gap >> k) & 1) != 0) x = ancestor_tab[x][k];
    end
    if (x == y) return x;
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (ancestor_tab[x][lv] != ancestor_tab[y][lv]) begin
        x = ancestor_tab[x][lv];
        y = ancestor_tab[y][lv];
      end
    end
    return ancestor_tab[x][0];
  endfunction

  function automatic void queue_word(logic [1:0] op, node_t a, node_t b, node_t p, node_t d);
    tree_word_t w;
    w.op  = op;
    w.a   = a;
    w.b   = b;
    w.par = p;
    w.dep = d;
    pending_q.insert(pending_q.size(), w);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Sender: a new word goes out at the falling edge once the previous one was taken. A word
  // that the unit stalls stays on the ports unchanged. Idle gaps fall at random, except in a
  // window of words where the sender offers back to back.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk_i) begin
    tree_word_t w;
    bit         rest;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      rest = ($urandom_range(0, 99) < 17) && !(words_sent >= 300 && words_sent < 420);
      if (pending_q.size() != 0 && !rest) begin
        w = pending_q.pop_front();
        op_i          <= w.op;
        node_a_i      <= w.a;
        node_b_i      <= w.b;
        parent_node_i <= w.par;
        depth_value_i <= w.dep;
        in_valid_i    <= 1'b1;
        words_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: stalls at random, never in a window of answers, and twice holds off for a long
  // stretch so that a finished answer sits in the output register while the next query
  // completes and the unit has to stall its input.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (hold_marks < 2 && answers_seen >= (hold_marks == 0 ? 40 : 200)) begin
        out_stall_i <= 1'b1;
        hold_left   <= HoldCycles;
        hold_marks  <= hold_marks + 1;
      end else if (answers_seen >= 120 && answers_seen < 190) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 17);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: at each rising edge, an answer that is taken is compared with the oldest owed
  // ancestor, and a word that is taken updates the predictor. An answer can never leave in
  // the cycle its query arrives, so the order of the two steps does not matter.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    node_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        answers_seen++;
        if (lca_due_q.size() == 0) begin
          $display("%0t: ancestor word with no query waiting: expected none, got %0d",
                   $time, ancestor_node_o);
          fails++;
        end else begin
          want = lca_due_q.pop_front();
          if (ancestor_node_o !== want) begin
            $display("%0t: ancestor_node mismatch: expected %0d, got %0d",
                     $time, want, ancestor_node_o);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        case (op_i)
          bllca_pkg::OP_LOAD:  lca_store(node_a_i, parent_node_i, depth_value_i);
          bllca_pkg::OP_BUILD: lca_rebuild();
          bllca_pkg::OP_QUERY:
            lca_due_q.insert(lca_due_q.size(), lca_answer(node_a_i, node_b_i));
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus and end of run. Every query touches only nodes of the tree loaded and built in
  // the same phase, so no query reads a table entry that was never written.
  // ---------------------------------------------------------------------------------------
  initial begin
    int    pool [NODES];
    int    up_idx [$];
    int    lvl [$];
    int    tree_size [5];
    int    query_cnt [5];
    int    i, j, x, y, tmp, d;
    bit    chain, noisy;
    node_t dv;

    for (i = 0; i < NODES; i++) begin
      depth_tab[i] = '0;
      for (j = 0; j < LEVELS; j++) ancestor_tab[i][j] = '0;
    end

    // Directed part: a small tree rooted at the highest node with node zero under it, and a
    // leaf that claims the largest depth so that lifting uses every difference bit but the lowest.
    queue_word(bllca_pkg::OP_LOAD, 10'd1023, 10'd0, 10'd1023, 10'd0);
    queue_word(bllca_pkg::OP_LOAD, 10'd0, 10'd1023, 10'd1023, 10'd1);
    queue_word(bllca_pkg::OP_LOAD, 10'd5, 10'd0, 10'd0, 10'd2);
    queue_word(bllca_pkg::OP_LOAD, 10'd6, 10'd0, 10'd0, 10'd2);
    queue_word(bllca_pkg::OP_LOAD, 10'd7, 10'd0, 10'd5, 10'd3);
    queue_word(bllca_pkg::OP_LOAD, 10'd8, 10'd0, 10'd1023, 10'd1);
    queue_word(bllca_pkg::OP_LOAD, 10'd9, 10'd0, 10'd7, 10'd1023);
    // The spare op code must be dropped without an answer.
    queue_word(OP_SPARE, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    queue_word(bllca_pkg::OP_BUILD, 10'd0, 10'd0, 10'd0, 10'd0);
    queue_word(bllca_pkg::OP_QUERY, 10'd7, 10'd6, 10'd1023, 10'd1023);  // meet at node zero
    queue_word(bllca_pkg::OP_QUERY, 10'd6, 10'd7, 10'd0, 10'd0);  // same pair, shallower first
    queue_word(bllca_pkg::OP_QUERY, 10'd7, 10'd7, 10'd0, 10'd0);  // a node with itself
    queue_word(bllca_pkg::OP_QUERY, 10'd7, 10'd0, 10'd0, 10'd0);  // ancestor answers at once
    queue_word(bllca_pkg::OP_QUERY, 10'd0, 10'd7, 10'd0, 10'd0);
    queue_word(bllca_pkg::OP_QUERY, 10'd1023, 10'd1023, 10'd1023, 10'd1023);  // root, itself
    queue_word(bllca_pkg::OP_QUERY, 10'd8, 10'd7, 10'd0, 10'd0);  // meet at the root
    queue_word(bllca_pkg::OP_QUERY, 10'd9, 10'd8, 10'd1023, 10'd0);  // huge depth difference
    queue_word(bllca_pkg::OP_QUERY, 10'd9, 10'd9, 10'd0, 10'd1023);
    queue_word(bllca_pkg::OP_QUERY, 10'd0, 10'd1023, 10'd0, 10'd0);
    queue_word(bllca_pkg::OP_QUERY, 10'd5, 10'd6, 10'd0, 10'd0);  // siblings

    // Random phases: a fresh tree over randomly chosen node numbers, one build, then a run
    // of queries with a little noise mixed in.
    tree_size[0] = 60;  query_cnt[0] = 90;
    tree_size[1] = 150; query_cnt[1] = 80;
    tree_size[2] = 40;  query_cnt[2] = 70;
    tree_size[3] = 20;  query_cnt[3] = 60;
    tree_size[4] = 80;  query_cnt[4] = 60;

    for (int ph = 0; ph < 5; ph++) begin
      // Long thin trees (phase one, at random four) give deep nodes; one phase lies about depths.
      chain = (ph == 1) || (ph == 4 && $urandom_range(0, 1) == 1);
      noisy = (ph == 2);

      for (i = 0; i < NODES; i++) pool[i] = i;
      for (i = NODES - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = pool[i];
        pool[i] = pool[j];
        pool[j] = tmp;
      end

      up_idx.delete();
      lvl.delete();
      for (i = 0; i < tree_size[ph]; i++) begin
        if (i == 0) begin
          j = 0;
          d = 0;
        end else begin
          j = chain ? $urandom_range((i > 3) ? i - 3 : 0, i - 1) : $urandom_range(0, i - 1);
          d = lvl[j] + 1;
        end
        up_idx.insert(up_idx.size(), j);
        lvl.insert(lvl.size(), d);
        dv = (noisy && $urandom_range(0, 7) == 0) ? node_t'($urandom_range(0, 1023)) :
                                                    node_t'(d);
        queue_word(bllca_pkg::OP_LOAD, node_t'(pool[i]), node_t'($urandom_range(0, 1023)),
                   node_t'(pool[j]), dv);
        if ($urandom_range(0, 15) == 0)
          queue_word(OP_SPARE, node_t'($urandom_range(0, 1023)),
                     node_t'($urandom_range(0, 1023)), node_t'($urandom_range(0, 1023)),
                     node_t'($urandom_range(0, 1023)));
      end

      queue_word(bllca_pkg::OP_BUILD, node_t'($urandom_range(0, 1023)),
                 node_t'($urandom_range(0, 1023)), node_t'($urandom_range(0, 1023)),
                 node_t'($urandom_range(0, 1023)));

      for (int q = 0; q < query_cnt[ph]; q++) begin
        x = $urandom_range(0, tree_size[ph] - 1);
        case ($urandom_range(0, 9))
          0: y = x;
          1, 2, 3: begin
            // An ancestor a few steps up, so the answer comes right after lifting.
            y = x;
            repeat ($urandom_range(1, 8)) y = up_idx[y];
          end
          default: y = $urandom_range(0, tree_size[ph] - 1);
        endcase
        if ($urandom_range(0, 1) == 1) begin
          tmp = x;
          x = y;
          y = tmp;
        end
        queue_word(bllca_pkg::OP_QUERY, node_t'(pool[x]), node_t'(pool[y]),
                   node_t'($urandom_range(0, 1023)), node_t'($urandom_range(0, 1023)));

        // Now and then a node of the tree is reloaded without a new build. Its upper levels
        // stay as the last build left them, which the unit must honor as well.
        if ($urandom_range(0, 24) == 0)
          queue_word(bllca_pkg::OP_LOAD, node_t'(pool[$urandom_range(0, tree_size[ph] - 1)]),
                     node_t'($urandom_range(0, 1023)),
                     node_t'(pool[$urandom_range(0, tree_size[ph] - 1)]),
                     node_t'($urandom_range(0, 1023)));
        if ($urandom_range(0, 19) == 0)
          queue_word(OP_SPARE, node_t'($urandom_range(0, 1023)),
                     node_t'($urandom_range(0, 1023)), node_t'($urandom_range(0, 1023)),
                     node_t'($urandom_range(0, 1023)));
      end
    end

    // Reset is released on a falling edge.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last word to be taken and the last answer to arrive, then a little more
    // so that any answer nobody asked for would still be seen.
    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (lca_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fails == 0) begin
      $display("binary_lifting_lca_unit test passed");
    end else begin
      $display("binary_lifting_lca_unit test failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bllca_pkg.sv
hw/rtl/bllca_depth_mem.sv
hw/rtl/bllca_jump_mem.sv
hw/rtl/bllca_ctrl.sv
hw/rtl/binary_lifting_lca_unit.sv
tb/tb_top.sv
